>>> hdl/sik_pkg.sv
// Shared constants, widths and arctangent table for the SCARA inverse kinematics block.
// No dependencies.
package sik_pkg;

  localparam int unsigned CordicStagesDef = 20;
  localparam int unsigned LenW   = 20;
  localparam int unsigned PosW   = 24;
  localparam int unsigned AngW   = 27;
  localparam int unsigned FracC  = 20;
  localparam int unsigned CW     = 22;  // signed Q.20 cosine/sine
  localparam int unsigned NumW   = 52;  // signed elbow numerator
  localparam int unsigned DenW   = 41;  // 2*L1*L2
  localparam int unsigned VecW   = 56;  // CORDIC vector width, signed
  localparam int unsigned ZW     = 28;  // CORDIC angle accumulator, signed
  localparam int unsigned SqW    = 42;  // 2^40 - C^2 radicand
  localparam int unsigned QW     = 21;  // cosine quotient magnitude
  localparam logic signed [ZW-1:0] Deg180 = ZW'(180 * 65536);

  typedef enum logic [2:0] {
    RegUpperLen = 3'd0,
    RegLowerLen = 3'd1,
    RegOffsetX  = 3'd2,
    RegOffsetY  = 3'd3,
    RegPassMode = 3'd4
  } reg_idx_e;

  function automatic logic [ZW-1:0] atan_deg(input int unsigned i);
    logic [ZW-1:0] r;
    case (i)
      0: r = ZW'(2949120);  1: r = ZW'(1740967);  2: r = ZW'(919879);
      3: r = ZW'(466945);   4: r = ZW'(234379);   5: r = ZW'(117304);
      6: r = ZW'(58666);    7: r = ZW'(29335);    8: r = ZW'(14668);
      9: r = ZW'(7334);     10: r = ZW'(3667);    11: r = ZW'(1833);
      12: r = ZW'(917);     13: r = ZW'(458);     14: r = ZW'(229);
      15: r = ZW'(115);     16: r = ZW'(57);      17: r = ZW'(29);
      18: r = ZW'(14);      19: r = ZW'(7);       20: r = ZW'(4);
      21: r = ZW'(2);       22: r = ZW'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

  // Per-item side data carried alongside the pipeline.
  typedef struct packed {
    logic                   pass;
    logic                   flag;
    logic signed [PosW-1:0] tx;
    logic signed [PosW-1:0] ty;
    logic signed [PosW-1:0] tz;
  } side_t;

endpackage

>>> hdl/sik_div_cell.sv
// One restoring-division cell: produces one quotient bit per item and hands
// the partial remainder to its neighbor. Uses sik_pkg.
module sik_div_cell import sik_pkg::*; #(
  parameter int unsigned Bit = 0
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [DenW:0]   rem_i,
  input  logic [NumW+FracC-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  input  logic [QW-1:0]   q_i,
  output logic [DenW:0]   rem_o,
  output logic [NumW+FracC-1:0] num_o,
  output logic [DenW-1:0] den_o,
  output logic [QW-1:0]   q_o
);
  logic [DenW+1:0] trial;
  logic [DenW:0]   rem_d;
  logic            qb;

  always_comb begin
    trial = {rem_i, num_i[NumW+FracC-1]};
    qb    = trial >= {1'b0, den_i};
    rem_d = qb ? (DenW+1)'(trial - {1'b0, den_i}) : trial[DenW:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o <= rem_d;
      num_o <= {num_i[NumW+FracC-2:0], 1'b0};
      den_o <= den_i;
      q_o   <= {q_i[QW-2:0], qb};
    end
  end
endmodule

>>> hdl/sik_sqrt_cell.sv
// One square-root cell: settles one root bit per item, passes remainder on.
// Uses sik_pkg.
module sik_sqrt_cell import sik_pkg::*; #(
  parameter int unsigned Step = 0
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [SqW-1:0] rad_i,
  input  logic [SqW-1:0] rem_i,
  input  logic [QW-1:0]  root_i,
  output logic [SqW-1:0] rad_o,
  output logic [SqW-1:0] rem_o,
  output logic [QW-1:0]  root_o
);
  logic [SqW+1:0] cur;
  logic [SqW+1:0] trial;
  logic           ok;

  always_comb begin
    cur   = {rem_i, rad_i[SqW-1:SqW-2]};
    trial = {(SqW+2-QW-2)'(0), root_i, 2'b01};
    ok    = cur >= trial;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_o  <= {rad_i[SqW-3:0], 2'b00};
      rem_o  <= ok ? SqW'(cur - trial) : SqW'(cur);
      root_o <= {root_i[QW-2:0], ok};
    end
  end
endmodule

>>> hdl/sik_cordic_cell.sv
// One vectoring CORDIC micro-rotation cell with fixed shift. Uses sik_pkg.
module sik_cordic_cell import sik_pkg::*; #(
  parameter int unsigned Shift = 0
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic signed [VecW-1:0] x_i,
  input  logic signed [VecW-1:0] y_i,
  input  logic signed [ZW-1:0]   z_i,
  output logic signed [VecW-1:0] x_o,
  output logic signed [VecW-1:0] y_o,
  output logic signed [ZW-1:0]   z_o
);
  localparam logic signed [ZW-1:0] Ang = atan_deg(Shift);
  logic signed [VecW-1:0] xs, ys;

  assign xs = x_i >>> Shift;
  assign ys = y_i >>> Shift;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (y_i > 0) begin
        x_o <= x_i + ys;
        y_o <= y_i - xs;
        z_o <= z_i + Ang;
      end else begin
        x_o <= x_i - ys;
        y_o <= y_i + xs;
        z_o <= z_i - Ang;
      end
    end
  end
endmodule

>>> hdl/sik_cordic.sv
// Pre-rotation and chain of CORDIC cells computing atan2(a, b) in Q.16 degrees.
// Uses sik_pkg and sik_cordic_cell.
module sik_cordic import sik_pkg::*; #(
  parameter int unsigned Stages = CordicStagesDef
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic signed [VecW-1:0] a_i,
  input  logic signed [VecW-1:0] b_i,
  output logic signed [ZW-1:0]   ang_o
);
  logic signed [VecW-1:0] x_c [Stages+1];
  logic signed [VecW-1:0] y_c [Stages+1];
  logic signed [ZW-1:0]   z_c [Stages+1];
  logic                   zero_c [Stages+1];
  logic                   zero_q [Stages+1];

  // Entry stage: fold the left half-plane onto the right.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_c[0] <= (a_i == '0) && (b_i == '0);
      if (b_i < 0) begin
        x_c[0] <= -b_i;
        y_c[0] <= -a_i;
        z_c[0] <= (a_i >= 0) ? Deg180 : -Deg180;
      end else begin
        x_c[0] <= b_i;
        y_c[0] <= a_i;
        z_c[0] <= '0;
      end
    end
  end

  assign zero_q[0] = zero_c[0];

  for (genvar g = 0; g < Stages; g++) begin : g_cell
    sik_cordic_cell #(.Shift(g)) u_cell (
      .clk_i, .en_i,
      .x_i(x_c[g]), .y_i(y_c[g]), .z_i(z_c[g]),
      .x_o(x_c[g+1]), .y_o(y_c[g+1]), .z_o(z_c[g+1])
    );
    always_ff @(posedge clk_i) begin
      if (en_i) zero_c[g+1] <= zero_q[g];
    end
    assign zero_q[g+1] = zero_c[g+1];
  end

  assign ang_o = zero_q[Stages] ? '0 : z_c[Stages];
endmodule

>>> hdl/scara_inverse_kinematics.sv
// SCARA inverse kinematics top level: configuration registers, setup stages,
// divider, square-root and CORDIC chains. Uses sik_pkg and the sik_* cells.
//
// One item enters per clock unless the pipeline stalls. Its path runs through
// 4 setup stages, 21 divider cells, 1 cosine stage, 21 root cells, 2 vector
// stages (link multiply), then CORDIC_STAGES+1 cells, then 1 output register;
// CORDIC_STAGES defaults to 20. The whole pipeline advances together on one
// enable that stalls only when the output register is full and not taken, so
// the input is ready whenever the result register is empty or being drained.
// Each arm of the arithmetic is a row of identical cells: one
// restoring-division cell per cosine bit, one square-root cell per sine bit,
// one micro-rotation per CORDIC step. An unreachable target clamps the cosine
// to +/-1 and sets out_of_reach_o; in pass-through mode the angle outputs carry
// the raw x and y instead.
module scara_inverse_kinematics import sik_pkg::*; #(
  parameter int unsigned CORDIC_STAGES = CordicStagesDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [2:0]             cfg_index_i,
  input  logic [31:0]            cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic signed [PosW-1:0] target_x_i,
  input  logic signed [PosW-1:0] target_y_i,
  input  logic signed [PosW-1:0] target_z_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic signed [AngW-1:0] shoulder_angle_o,
  output logic signed [AngW-1:0] elbow_angle_o,
  output logic signed [PosW-1:0] joint_z_o,
  output logic                   out_of_reach_o
);
  localparam int unsigned DivN = QW;
  localparam int unsigned SqN  = QW;
  localparam int unsigned Lat  = 4 + DivN + 1 + SqN + 2 + CORDIC_STAGES + 1;

  // Cosine class: divide, clamp to +one, clamp to -one.
  typedef enum logic [1:0] {
    ClsDivide = 2'd0,
    ClsPosOne = 2'd1,
    ClsNegOne = 2'd2
  } cls_e;

  logic [LenW-1:0] l1_q, l2_q;
  logic signed [PosW-1:0] offx_q, offy_q;
  logic pass_q;

  // Configuration writes: always accepted.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l1_q   <= LenW'(51200);
      l2_q   <= LenW'(51200);
      offx_q <= '0;
      offy_q <= '0;
      pass_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegUpperLen: l1_q   <= cfg_data_i[LenW-1:0];
        RegLowerLen: l2_q   <= cfg_data_i[LenW-1:0];
        RegOffsetX:  offx_q <= cfg_data_i[PosW-1:0];
        RegOffsetY:  offy_q <= cfg_data_i[PosW-1:0];
        RegPassMode: pass_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Pipeline enable: advance unless the result register holds an untaken transfer.
  logic en;
  logic [Lat-1:0] vld_q;
  assign en = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en) vld_q <= {vld_q[Lat-2:0], in_valid_i};
  end

  // Side data delay line, one slot per pipeline stage.
  side_t side_q [Lat];
  side_t side_in;
  side_t side3;
  logic  flag_s4;

  // Stage 1: shift target into arm frame.
  logic signed [PosW+1:0] px1_q, py1_q;
  logic [LenW-1:0] l1_1q, l2_1q;
  // Stage 2: squares.
  logic [2*PosW+3:0] pxx2_q, pyy2_q;
  logic [2*LenW-1:0] l11_2q, l22_2q, l12_2q;
  logic signed [PosW+1:0] px2_q, py2_q;
  logic [LenW-1:0] l1_2q, l2_2q;
  // Stage 3: numerator and denominator.
  logic signed [NumW-1:0] num3_q;
  logic [DenW-1:0] den3_q;
  logic signed [PosW+1:0] px3_q, py3_q;
  logic [LenW-1:0] l1_3q, l2_3q;
  // Stage 4: classification.
  cls_e       cls4_q;
  logic       neg4_q;
  logic [NumW-1:0] mag4_q;
  logic [DenW-1:0] den4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      px1_q  <= -(PosW+2)'(target_x_i) - (PosW+2)'(offx_q);
      py1_q  <= (PosW+2)'(target_y_i) + (PosW+2)'(offy_q);
      l1_1q  <= l1_q;
      l2_1q  <= l2_q;

      pxx2_q <= (2*PosW+4)'(px1_q * px1_q);
      pyy2_q <= (2*PosW+4)'(py1_q * py1_q);
      l11_2q <= l1_1q * l1_1q;
      l22_2q <= l2_1q * l2_1q;
      l12_2q <= l1_1q * l2_1q;
      px2_q  <= px1_q;  py2_q <= py1_q;
      l1_2q  <= l1_1q;  l2_2q <= l2_1q;

      num3_q <= NumW'(pxx2_q) + NumW'(pyy2_q) - NumW'(l11_2q) - NumW'(l22_2q);
      den3_q <= {l12_2q, 1'b0};
      px3_q  <= px2_q;  py3_q <= py2_q;
      l1_3q  <= l1_2q;  l2_3q <= l2_2q;

      neg4_q <= num3_q < 0;
      mag4_q <= num3_q < 0 ? NumW'(-num3_q) : NumW'(num3_q);
      den4_q <= den3_q;
      if (num3_q > $signed({(NumW-DenW)'(0), den3_q})) cls4_q <= ClsPosOne;
      else if (num3_q < -$signed({(NumW-DenW)'(0), den3_q})) cls4_q <= ClsNegOne;
      else if (den3_q == '0) cls4_q <= ClsPosOne;
      else cls4_q <= ClsDivide;
    end
  end

  assign flag_s4 = (num3_q > $signed({(NumW-DenW)'(0), den3_q}))
                || (num3_q < -$signed({(NumW-DenW)'(0), den3_q}));

  // Carry px/py and lengths along the long chain with the side data.
  typedef struct packed {
    logic signed [PosW+1:0] px;
    logic signed [PosW+1:0] py;
    logic [LenW-1:0] l1;
    logic [LenW-1:0] l2;
    cls_e cls;
    logic neg;
  } geo_t;
  localparam int unsigned GeoN = DivN + 1 + SqN;
  geo_t geo_q [GeoN+1];
  geo_t geo1;

  always_comb begin
    side_in.pass = pass_q;
    side_in.flag = 1'b0;
    side_in.tx   = target_x_i;
    side_in.ty   = target_y_i;
    side_in.tz   = target_z_i;
  end

  // Merge the reach flag and the cosine class in as their items pass by.
  always_comb begin
    side3      = side_q[2];
    side3.flag = flag_s4;
    geo1       = geo_q[0];
    geo1.cls   = cls4_q;
    geo1.neg   = neg4_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_in;
      for (int i = 1; i < Lat; i++) side_q[i] <= (i == 3) ? side3 : side_q[i-1];
      geo_q[0] <= '{px: px3_q, py: py3_q, l1: l1_3q, l2: l2_3q,
                    cls: ClsDivide, neg: 1'b0};
      for (int i = 1; i <= GeoN; i++) geo_q[i] <= (i == 1) ? geo1 : geo_q[i-1];
    end
  end

  // Divider chain: quotient of |num|*2^20 by den; top bits of num shift in.
  logic [DenW:0]   d_rem [DivN+1];
  logic [NumW+FracC-1:0] d_num [DivN+1];
  logic [DenW-1:0] d_den [DivN+1];
  logic [QW-1:0]   d_q   [DivN+1];

  // Leading part of the dividend fits in one remainder; rest streams through.
  assign d_rem[0] = (DenW+1)'(({mag4_q, FracC'(0)}) >> DivN);
  assign d_num[0] = {mag4_q, FracC'(0)} << (NumW + FracC - DivN);
  assign d_den[0] = den4_q;
  assign d_q[0]   = '0;

  for (genvar g = 0; g < DivN; g++) begin : g_div
    sik_div_cell #(.Bit(g)) u_div (
      .clk_i, .en_i(en),
      .rem_i(d_rem[g]), .num_i(d_num[g]), .den_i(d_den[g]), .q_i(d_q[g]),
      .rem_o(d_rem[g+1]), .num_o(d_num[g+1]), .den_o(d_den[g+1]), .q_o(d_q[g+1])
    );
  end

  // Cosine stage.
  logic signed [CW-1:0] c_q;
  logic [SqW-1:0] rad_q;
  logic signed [CW-1:0] cc;
  always_comb begin
    case (geo_q[DivN].cls)
      ClsPosOne: cc = CW'(1 << FracC);
      ClsNegOne: cc = -CW'(1 << FracC);
      default:   cc = geo_q[DivN].neg ? -CW'(d_q[DivN]) : CW'(d_q[DivN]);
    endcase
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      c_q   <= cc;
      rad_q <= SqW'(SqW'(1) << (2*FracC)) - SqW'(cc * cc);
    end
  end

  // Square-root chain.
  logic [SqW-1:0] s_rad [SqN+1];
  logic [SqW-1:0] s_rem [SqN+1];
  logic [QW-1:0]  s_root [SqN+1];
  logic signed [CW-1:0] c_dly [SqN+1];
  assign s_rad[0] = rad_q;
  assign s_rem[0] = '0;
  assign s_root[0] = '0;
  assign c_dly[0] = c_q;
  for (genvar g = 0; g < SqN; g++) begin : g_sq
    sik_sqrt_cell #(.Step(g)) u_sq (
      .clk_i, .en_i(en),
      .rad_i(s_rad[g]), .rem_i(s_rem[g]), .root_i(s_root[g]),
      .rad_o(s_rad[g+1]), .rem_o(s_rem[g+1]), .root_o(s_root[g+1])
    );
    always_ff @(posedge clk_i) begin
      if (en) c_dly[g+1] <= c_dly[g];
    end
  end

  // Vector stages: K1 = L1*2^20 + L2*C, K2 = L2*S.
  logic signed [VecW-1:0] k1_q, k2_q, pa_q, pb_q, sa_q, sb_q;
  logic signed [VecW-1:0] l2c_q, l2s_q, l1one_q, pa1_q, pb1_q, sa1_q, sb1_q;
  geo_t gv;
  assign gv = geo_q[DivN + 1 + SqN];
  always_ff @(posedge clk_i) begin
    if (en) begin
      l2c_q   <= VecW'($signed({1'b0, gv.l2}) * c_dly[SqN]);
      l2s_q   <= VecW'($signed({1'b0, gv.l2}) * $signed({1'b0, s_root[SqN]}));
      l1one_q <= VecW'({gv.l1, FracC'(0)});
      pa1_q   <= VecW'(gv.px) <<< FracC;
      pb1_q   <= VecW'(gv.py) <<< FracC;
      sa1_q   <= VecW'($signed({1'b0, s_root[SqN]})) <<< 8;
      sb1_q   <= VecW'(c_dly[SqN]) <<< 8;

      k1_q <= l1one_q + l2c_q;
      k2_q <= l2s_q;
      pa_q <= pa1_q;  pb_q <= pb1_q;
      sa_q <= sa1_q;  sb_q <= sb1_q;
    end
  end

  logic signed [ZW-1:0] ang_k, ang_p, ang_s;
  sik_cordic #(.Stages(CORDIC_STAGES)) u_cor_k (
    .clk_i, .en_i(en), .a_i(k1_q), .b_i(k2_q), .ang_o(ang_k));
  sik_cordic #(.Stages(CORDIC_STAGES)) u_cor_p (
    .clk_i, .en_i(en), .a_i(pa_q), .b_i(pb_q), .ang_o(ang_p));
  sik_cordic #(.Stages(CORDIC_STAGES)) u_cor_s (
    .clk_i, .en_i(en), .a_i(sa_q), .b_i(sb_q), .ang_o(ang_s));

  // Output stage: combine angles, then hold the result register.
  logic signed [ZW-1:0] sh_q, el_q;
  side_t so;
  logic signed [ZW-1:0] sh_d;
  assign so   = side_q[Lat-1];
  assign sh_d = ang_k - ang_p;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_o <= 1'b0;
    else if (en) out_valid_o <= vld_q[Lat-1];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (so.pass) begin
        shoulder_angle_o <= AngW'(so.tx);
        elbow_angle_o    <= AngW'(so.ty);
      end else begin
        shoulder_angle_o <= AngW'(sh_d);
        elbow_angle_o    <= AngW'(ang_s + sh_d);
      end
      joint_z_o      <= so.tz;
      out_of_reach_o <= so.flag;
    end
  end
endmodule

>>> hdl/sik_checker.sv
// Port-level checker for the SCARA inverse kinematics block, bound to the top.
// Uses sik_pkg.
module sik_checker import sik_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic out_of_reach_o,
  input logic signed [PosW-1:0] joint_z_o
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(joint_z_o))
    else $error("result dropped while stalled");
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result register");
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while result stalled");
  a_flag_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_of_reach_o))
    else $error("flag changed while stalled");
endmodule

bind scara_inverse_kinematics sik_checker u_sik_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
  .out_of_reach_o, .joint_z_o
);
